### rtl/pett_pkg.sv
// ----------------------------------------------------------------------------
// pett_pkg
// types and constants shared by the periodic event timer table unit
// ----------------------------------------------------------------------------
package pett_pkg;

  localparam int TIME_W      = 32;
  localparam int MAX_RESULTS = 16;
  localparam int FIRE_CNT_W  = 5;

  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_REGISTER = 3'd1;
  localparam logic [2:0] CMD_ENABLE   = 3'd2;
  localparam logic [2:0] CMD_DISABLE  = 3'd3;
  localparam logic [2:0] CMD_SET_THR  = 3'd4;

  typedef struct packed {
    logic [2:0]        command;
    logic [TIME_W-1:0] tick_time;
    logic [3:0]        event_index;
    logic [TIME_W-1:0] threshold;
  } in_item_t;

  typedef struct packed {
    logic       is_fire;
    logic [3:0] fired_index;
    logic [4:0] assigned_id;
    logic       ok;
    logic       last;
  } out_item_t;

  // accumulate step outcome for one table entry
  typedef struct packed {
    logic              wr;
    logic              hit;
    logic [TIME_W-1:0] value;
  } acc_res_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

endpackage

### rtl/pett_ram.sv
// ----------------------------------------------------------------------------
// pett_ram
// simple dual-port synchronous memory, one write and one registered read
// ----------------------------------------------------------------------------
module pett_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/pett_acc.sv
// ----------------------------------------------------------------------------
// pett_acc
// accumulate step: adds the tick delta to an entry and checks its period
// ----------------------------------------------------------------------------
module pett_acc
  import pett_pkg::*;
(
  input  logic              enable,
  input  logic [TIME_W-1:0] elapsed,
  input  logic [TIME_W-1:0] period,
  input  logic [TIME_W-1:0] delta,
  output acc_res_t          res
);

  logic [TIME_W-1:0] sum;

  always_comb begin
    sum       = elapsed + delta;
    res.wr    = enable;
    res.hit   = enable && (sum >= period);
    res.value = res.hit ? '0 : sum;
  end

endmodule

### rtl/periodic_event_timer_table_unit.sv
// ----------------------------------------------------------------------------
// periodic_event_timer_table_unit
// table of periodic event timers, period and accumulator held in memories
// ----------------------------------------------------------------------------
// register, enable, disable, set threshold: result in the cycle after the
//   transfer, busy stays low, one command per cycle
// tick: walks the registered entries one per cycle through the shared read
//   port of both memories, busy during walk and flush (none if table empty)
// results cannot be stalled; rst clears entry count, enables and time base
module periodic_event_timer_table_unit
  import pett_pkg::*;
#(
  parameter int NUM_EVENTS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  item,
  output logic      busy,
  output logic      result_valid,
  output out_item_t result
);

  localparam int IDX_W = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int CNT_W = $clog2(NUM_EVENTS + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam int ID_W  = (CNT_W > 5) ? CNT_W : 5;

  state_t                state, state_next;
  logic [CNT_W-1:0]      entry_total, entry_total_next;
  logic [TIME_W-1:0]     previous_time, previous_time_next;
  logic [TIME_W-1:0]     delta, delta_next;
  logic [NUM_EVENTS-1:0] enable_bits, enable_bits_next;
  logic [IDX_W-1:0]      cur, cur_next;
  logic [FIRE_CNT_W-1:0] fire_cnt, fire_cnt_next;
  logic                  pend_valid, pend_valid_next;
  logic [3:0]            pend_index, pend_index_next;
  logic                  result_valid_next;
  out_item_t             result_next;

  logic                  accept;
  logic [CMP_W-1:0]      idx_ext;
  logic [IDX_W-1:0]      idx_addr;
  logic                  idx_valid;
  logic                  full;
  logic [IDX_W-1:0]      total_addr;
  logic [CMP_W-1:0]      total_ext;
  logic [ID_W-1:0]       id_ext;
  logic [CMP_W-1:0]      cur_ext;
  logic                  cur_is_last;

  logic                  period_we;
  logic [IDX_W-1:0]      period_waddr;
  logic                  elapsed_we;
  logic [IDX_W-1:0]      elapsed_waddr;
  logic [TIME_W-1:0]     elapsed_wdata;
  logic [IDX_W-1:0]      raddr;
  logic [TIME_W-1:0]     period_rd;
  logic [TIME_W-1:0]     elapsed_rd;
  acc_res_t              acc;

  assign busy        = (state != ST_IDLE);
  assign accept      = start && !busy;
  assign idx_ext     = CMP_W'(item.event_index);
  assign idx_addr    = idx_ext[IDX_W-1:0];
  assign idx_valid   = idx_ext < CMP_W'(entry_total);
  assign full        = (entry_total == CNT_W'(NUM_EVENTS));
  assign total_addr  = entry_total[IDX_W-1:0];
  assign total_ext   = CMP_W'(entry_total);
  assign id_ext      = ID_W'(entry_total) + ID_W'(1);
  assign cur_ext     = CMP_W'(cur);
  assign cur_is_last = (CNT_W'(cur) + CNT_W'(1)) == entry_total;

  assign elapsed_waddr = (state == ST_WALK) ? cur : total_addr;
  assign elapsed_wdata = (state == ST_WALK) ? acc.value : '0;
  assign raddr         = (state == ST_WALK) ? (cur + IDX_W'(1)) : '0;

  pett_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_EVENTS)
  ) u_period_ram (
    .clk   (clk),
    .we    (period_we),
    .waddr (period_waddr),
    .wdata (item.threshold),
    .raddr (raddr),
    .rdata (period_rd)
  );

  pett_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_EVENTS)
  ) u_elapsed_ram (
    .clk   (clk),
    .we    (elapsed_we),
    .waddr (elapsed_waddr),
    .wdata (elapsed_wdata),
    .raddr (raddr),
    .rdata (elapsed_rd)
  );

  pett_acc u_acc (
    .enable  (enable_bits[cur]),
    .elapsed (elapsed_rd),
    .period  (period_rd),
    .delta   (delta),
    .res     (acc)
  );

  always_comb begin
    state_next         = state;
    entry_total_next   = entry_total;
    previous_time_next = previous_time;
    delta_next         = delta;
    enable_bits_next   = enable_bits;
    cur_next           = cur;
    fire_cnt_next      = fire_cnt;
    pend_valid_next    = pend_valid;
    pend_index_next    = pend_index;
    result_valid_next  = 1'b0;
    result_next        = result;
    period_we          = 1'b0;
    period_waddr       = total_addr;
    elapsed_we         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          result_next.is_fire     = 1'b0;
          result_next.fired_index = '0;
          result_next.assigned_id = '0;
          result_next.ok          = 1'b0;
          result_next.last        = 1'b1;
          unique case (item.command)
            CMD_TICK: begin
              delta_next         = item.tick_time - previous_time;
              previous_time_next = item.tick_time;
              cur_next           = '0;
              fire_cnt_next      = '0;
              pend_valid_next    = 1'b0;
              if (entry_total != '0) begin
                state_next = ST_WALK;
              end
            end
            CMD_REGISTER: begin
              result_valid_next = 1'b1;
              if (!full) begin
                period_we                     = 1'b1;
                elapsed_we                    = 1'b1;
                enable_bits_next[total_addr]  = 1'b1;
                entry_total_next              = entry_total + CNT_W'(1);
                result_next.fired_index       = total_ext[3:0];
                result_next.assigned_id       = id_ext[4:0];
                result_next.ok                = 1'b1;
              end
            end
            CMD_ENABLE, CMD_DISABLE, CMD_SET_THR: begin
              result_valid_next       = 1'b1;
              result_next.fired_index = item.event_index;
              result_next.ok          = idx_valid;
              if (idx_valid) begin
                enable_bits_next[idx_addr] = (item.command != CMD_DISABLE);
                if (item.command == CMD_SET_THR) begin
                  period_we    = 1'b1;
                  period_waddr = idx_addr;
                end
              end
            end
            default: begin
              result_valid_next = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        elapsed_we = acc.wr;
        if (acc.hit && (fire_cnt < FIRE_CNT_W'(MAX_RESULTS))) begin
          fire_cnt_next   = fire_cnt + FIRE_CNT_W'(1);
          pend_valid_next = 1'b1;
          pend_index_next = cur_ext[3:0];
          if (pend_valid) begin
            result_valid_next       = 1'b1;
            result_next.is_fire     = 1'b1;
            result_next.fired_index = pend_index;
            result_next.assigned_id = '0;
            result_next.ok          = 1'b1;
            result_next.last        = 1'b0;
          end
        end
        if (cur_is_last) begin
          state_next = ST_FLUSH;
        end else begin
          cur_next = cur + IDX_W'(1);
        end
      end
      ST_FLUSH: begin
        if (pend_valid) begin
          result_valid_next       = 1'b1;
          result_next.is_fire     = 1'b1;
          result_next.fired_index = pend_index;
          result_next.assigned_id = '0;
          result_next.ok          = 1'b1;
          result_next.last        = 1'b1;
        end
        pend_valid_next = 1'b0;
        state_next      = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      entry_total   <= '0;
      previous_time <= '0;
      enable_bits   <= '0;
      fire_cnt      <= '0;
      pend_valid    <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state         <= state_next;
      entry_total   <= entry_total_next;
      previous_time <= previous_time_next;
      enable_bits   <= enable_bits_next;
      fire_cnt      <= fire_cnt_next;
      pend_valid    <= pend_valid_next;
      result_valid  <= result_valid_next;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    delta      <= delta_next;
    cur        <= cur_next;
    pend_index <= pend_index_next;
    result     <= result_next;
  end

endmodule
